### rtl/core/rtpd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the redundant text payload deframer.
// No dependencies; imported by every module of the block.
package rtpd_pkg;

    // Default number of redundancy headers held per packet (legal 1 to 15).
    localparam int RTPD_MAX_BLOCKS = 8;

    localparam int OFFSET_W = 14;
    localparam int LENGTH_W = 10;
    localparam int PT_W     = 7;

    // One input beat: a payload byte plus the packet header values.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic        is_redundant_format;
        logic [31:0] pkt_timestamp;
        logic [15:0] pkt_seq;
        logic        pkt_mark;
    } t_in_beat;

    // One output beat: a recovered byte with its block attributes.
    typedef struct packed {
        logic [7:0]  out_byte;
        logic [31:0] out_timestamp;
        logic [15:0] out_seq;
        logic        out_mark;
        logic        block_end;
        logic        from_redundant;
        logic        empty_block;
        logic        error;
    } t_out_beat;

    // Parser result handed to the output register.
    typedef struct packed {
        logic      emit;
        t_out_beat beat;
    } t_result;

endpackage

### rtl/core/red_text_payload_deframer_unit.sv
`timescale 1ns / 1ps
// Top level of the redundant text payload deframer.
// Depends on rtpd_pkg, rtpd_in_reg, rtpd_parser and rtpd_out_reg.
//
//  channel   direction  handshake                 beat
//  -------   ---------  ------------------------  ---------------------------
//  in        sink       i_in_valid / o_in_stall   t_in_beat  (one payload byte)
//  out       source     o_out_valid / i_out_stall t_out_beat (zero or one/byte)
//  cfg       sink       i_cfg_we                  i_cfg_wdata (codec_enabled)
//
// One byte is taken per clock while the output is not stalled. An accepted byte is
// held in the input register while the parser works on it; its result (if any)
// then loads the output register, which drives o_out_valid, once that register has room.
// Reset (synchronous, active low) leaves the block idle with the codec off.
// A stall on the output holds the output beat; the input register then holds
// one more beat and the input stalls until the output drains.
module red_text_payload_deframer_unit
    import rtpd_pkg::*;
#(
    parameter int MAX_BLOCKS = RTPD_MAX_BLOCKS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    logic     w_item_valid;
    t_in_beat w_item;
    logic     w_room;
    logic     w_step;
    t_result  w_result;

    // Advance a held beat whenever the output register can take its result.
    assign w_step = w_item_valid && w_room;

    rtpd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_data  (i_in_data),
        .i_take  (w_step),
        .o_valid (w_item_valid),
        .o_data  (w_item)
    );

    rtpd_parser #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_item      (w_item),
        .o_result    (w_result)
    );

    rtpd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (w_result),
        .i_step   (w_step),
        .o_room   (w_room),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_data   (o_out_data)
    );

endmodule

### rtl/core/rtpd_in_reg.sv
`timescale 1ns / 1ps
// Input register of the deframer: holds one accepted beat until the parser takes it.
// Depends on rtpd_pkg.
module rtpd_in_reg
    import rtpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_in_beat i_data,
    input  logic     i_take,
    output logic     o_valid,
    output t_in_beat o_data
);

    logic     r_valid;
    t_in_beat r_data;

    assign o_stall = r_valid && !i_take;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_data <= i_data;
        end
    end

endmodule

### rtl/core/rtpd_parser.sv
`timescale 1ns / 1ps
// Parse state, header tables and per-byte result logic of the deframer.
// Depends on rtpd_pkg.
module rtpd_parser
    import rtpd_pkg::*;
#(
    parameter int MAX_BLOCKS = RTPD_MAX_BLOCKS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_we,
    input  logic     i_cfg_wdata,
    input  logic     i_step,
    input  t_in_beat i_item,
    output t_result  o_result
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PLAIN,
        PH_HDR,
        PH_RED,
        PH_PRIM,
        PH_DISCARD
    } t_phase;

    logic                r_enabled;
    t_phase              r_phase,     n_phase;
    logic [1:0]          r_hdr_idx,   n_hdr_idx;
    logic [7:0]          r_held,      n_held;
    logic [CNT_W-1:0]    r_hdr_cnt,   n_hdr_cnt;
    logic [IDX_W-1:0]    r_blk,       n_blk;
    logic [LENGTH_W-1:0] r_left,      n_left;

    logic [OFFSET_W-1:0] r_off [MAX_BLOCKS];
    logic [LENGTH_W-1:0] r_len [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] r_nz;

    logic                off_we, len_we;
    logic [LENGTH_W-1:0] len_wdata;

    logic [1:0]       c_hdr_idx;
    logic [CNT_W-1:0] c_hdr_cnt;
    t_phase           c_phase;

    logic [CNT_W-1:0] seek_start;
    logic             seek_hit;
    logic [IDX_W-1:0] seek_idx;

    logic [LENGTH_W-1:0] left_dec;
    logic                blk_done;
    t_in_beat            it;
    t_result             res;

    assign it = i_item;

    // First non-empty block at or after seek_start among the headers seen.
    always_comb begin
        seek_hit = 1'b0;
        seek_idx = '0;
        for (int j = MAX_BLOCKS - 1; j >= 0; j--) begin
            if (r_nz[j] && (CNT_W'(j) >= seek_start) && (CNT_W'(j) < c_hdr_cnt)) begin
                seek_hit = 1'b1;
                seek_idx = IDX_W'(j);
            end
        end
    end

    assign left_dec  = r_left - 1'b1;
    assign blk_done  = (left_dec == '0);
    assign len_wdata = {r_held[1:0], it.data_byte};

    always_comb begin
        // A redundant packet starts with fresh header counters.
        c_phase    = r_phase;
        c_hdr_idx  = r_hdr_idx;
        c_hdr_cnt  = r_hdr_cnt;
        if (r_phase == PH_IDLE && it.is_redundant_format) begin
            c_phase   = PH_HDR;
            c_hdr_idx = '0;
            c_hdr_cnt = '0;
        end

        n_phase    = c_phase;
        n_hdr_idx  = c_hdr_idx;
        n_held     = r_held;
        n_hdr_cnt  = c_hdr_cnt;
        n_blk      = r_blk;
        n_left     = r_left;
        off_we     = 1'b0;
        len_we     = 1'b0;
        seek_start = (c_phase == PH_RED) ? CNT_W'(r_blk) + 1'b1 : '0;

        res                     = '0;
        res.beat.out_byte       = it.data_byte;
        res.beat.out_timestamp  = it.pkt_timestamp;
        res.beat.out_seq        = it.pkt_seq;
        res.beat.out_mark       = it.pkt_mark;

        unique case (c_phase)
            PH_IDLE, PH_PLAIN, PH_PRIM: begin
                res.emit           = 1'b1;
                res.beat.block_end = it.last_byte;
                n_phase            = it.last_byte ? PH_IDLE : c_phase;
                if (c_phase == PH_IDLE && !it.last_byte) begin
                    n_phase = PH_PLAIN;
                end
            end
            PH_HDR: begin
                unique case (c_hdr_idx)
                    2'd0: begin
                        if (!it.data_byte[PT_W]) begin
                            // Primary header: jump to the first non-empty block.
                            if (seek_hit) begin
                                n_phase = PH_RED;
                                n_blk   = seek_idx;
                                n_left  = r_len[seek_idx];
                            end else begin
                                n_phase = PH_PRIM;
                                n_blk   = '0;
                                n_left  = '0;
                            end
                        end else if (c_hdr_cnt >= CNT_W'(MAX_BLOCKS)) begin
                            n_phase = PH_DISCARD;
                        end else begin
                            n_hdr_idx = 2'd1;
                        end
                    end
                    2'd1: begin
                        n_held    = it.data_byte;
                        n_hdr_idx = 2'd2;
                    end
                    2'd2: begin
                        off_we    = 1'b1;
                        n_held    = {6'd0, it.data_byte[1:0]};
                        n_hdr_idx = 2'd3;
                    end
                    default: begin
                        len_we    = 1'b1;
                        n_hdr_cnt = c_hdr_cnt + 1'b1;
                        n_hdr_idx = 2'd0;
                    end
                endcase
                if (it.last_byte) begin
                    n_phase            = PH_IDLE;
                    res.emit           = 1'b1;
                    res.beat.out_byte  = '0;
                    res.beat.block_end = 1'b1;
                    if (c_hdr_idx == 2'd0 && !it.data_byte[PT_W]) begin
                        // Header block ended right at the primary header.
                        res.beat.error       = seek_hit;
                        res.beat.empty_block = !seek_hit;
                    end else begin
                        res.beat.error = 1'b1;
                    end
                end
            end
            PH_RED: begin
                res.emit                = 1'b1;
                res.beat.from_redundant = 1'b1;
                res.beat.out_timestamp  = it.pkt_timestamp - 32'(r_off[r_blk]);
                res.beat.out_seq        = it.pkt_seq - 16'(r_hdr_cnt) + 16'(r_blk);
                res.beat.block_end      = blk_done;
                n_left                  = left_dec;
                if (blk_done) begin
                    if (seek_hit) begin
                        n_blk  = seek_idx;
                        n_left = r_len[seek_idx];
                    end else begin
                        n_phase = PH_PRIM;
                        n_blk   = '0;
                        n_left  = '0;
                    end
                    res.beat.error = seek_hit && it.last_byte;
                end else begin
                    res.beat.error = it.last_byte;
                end
                if (it.last_byte) begin
                    n_phase            = PH_IDLE;
                    res.beat.block_end = 1'b1;
                end
            end
            default: begin
                // Drop the rest of an overflowed packet; flag at its end.
                if (it.last_byte) begin
                    n_phase            = PH_IDLE;
                    res.emit           = 1'b1;
                    res.beat.out_byte  = '0;
                    res.beat.block_end = 1'b1;
                    res.beat.error     = 1'b1;
                end
            end
        endcase

        if (!r_enabled) begin
            res.emit = 1'b0;
        end
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_phase   <= PH_IDLE;
            r_hdr_idx <= '0;
            r_held    <= '0;
            r_hdr_cnt <= '0;
            r_blk     <= '0;
            r_left    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
            if (i_step && r_enabled) begin
                r_phase   <= n_phase;
                r_hdr_idx <= n_hdr_idx;
                r_held    <= n_held;
                r_hdr_cnt <= n_hdr_cnt;
                r_blk     <= n_blk;
                r_left    <= n_left;
            end
        end
    end

    // Header tables: written at the current header count, no reset.
    always_ff @(posedge i_clk) begin
        if (i_step && r_enabled && off_we) begin
            r_off[r_hdr_cnt[IDX_W-1:0]] <= {r_held, it.data_byte[7:2]};
        end
        if (i_step && r_enabled && len_we) begin
            r_len[r_hdr_cnt[IDX_W-1:0]] <= len_wdata;
            r_nz[r_hdr_cnt[IDX_W-1:0]]  <= (len_wdata != '0);
        end
    end

endmodule

### rtl/core/rtpd_out_reg.sv
`timescale 1ns / 1ps
// Output register of the deframer: holds one result beat until it is taken.
// Depends on rtpd_pkg.
module rtpd_out_reg
    import rtpd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_result   i_result,
    input  logic      i_step,
    output logic      o_room,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    logic      r_valid;
    t_out_beat r_data;

    assign o_room  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_room) begin
            r_valid <= i_step && i_result.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_room && i_step && i_result.emit) begin
            r_data <= i_result.beat;
        end
    end

endmodule

### tb/red_text_payload_deframer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for red_text_payload_deframer_unit: directed and random text packets.
// Depends on rtpd_pkg and the deframer RTL; holds its own block-recovery predictor.
module red_text_payload_deframer_unit_test;
    import rtpd_pkg::*;

    localparam int NBLK          = RTPD_MAX_BLOCKS;
    localparam int ITEM_TARGET   = 1550;
    localparam int SPLIT_TARGET  = 700;
    localparam int HOLD_AT       = 400;
    localparam int HOLD_CYCLES   = 150;
    localparam int SETTLE_CYCLES = 6;      // two-stage pipe plus margin
    localparam int TIMEOUT_NS    = 30_000_000;
    localparam int REPORT_LIMIT  = 10;

    // Header byte 0: bit 7 is the F flag, set on redundancy headers, clear on the primary header.
    localparam int   HDR_F_BIT   = 7;
    localparam logic HDR_FOLLOWS = 1'b1;
    localparam logic HDR_PRIMARY = 1'b0;

    typedef enum logic [2:0] {
        ST_WAIT_FIRST,
        ST_PLAIN,
        ST_HEADERS,
        ST_REDUNDANT,
        ST_PRIMARY,
        ST_DISCARD
    } t_parse_state;

    // Predicts the recovered block bytes and holds them until the block hands them out.
    class text_block_tracker;
        bit           codec_on;
        t_parse_state state;
        logic [1:0]   hdr_byte_idx;
        logic [7:0]   held;
        logic [13:0]  off_tab [NBLK];
        logic [9:0]   len_tab [NBLK];
        logic [3:0]   hdr_cnt;
        logic [3:0]   blk_idx;
        logic [9:0]   left;
        bit           overflow;
        t_out_beat    pending_block_bytes[$];
        int           checked, failures, mismatches;
        int           red_beats, err_beats, empty_beats;

        function new();
            int j;
            codec_on     = 1'b0;
            state        = ST_WAIT_FIRST;
            hdr_byte_idx = '0;
            held         = '0;
            hdr_cnt      = '0;
            blk_idx      = '0;
            left         = '0;
            overflow     = 1'b0;
            for (j = 0; j < NBLK; j++) begin
                off_tab[j] = '0;
                len_tab[j] = '0;
            end
        endfunction

        function t_out_beat pack_beat(logic [7:0] d, logic [31:0] ts, logic [15:0] sq,
                                      logic mk, logic fin, logic red, logic emp, logic err);
            t_out_beat r;
            r.out_byte       = d;
            r.out_timestamp  = ts;
            r.out_seq        = sq;
            r.out_mark       = mk;
            r.block_end      = fin;
            r.from_redundant = red;
            r.empty_block    = emp;
            r.error          = err;
            return r;
        endfunction

        // Move to the next non-empty redundant block at or after start, else to the primary.
        function bit seek_next_block(int start);
            int j;
            for (j = start; j < hdr_cnt && j < NBLK; j++) begin
                if (len_tab[j] != 0) begin
                    blk_idx = 4'(j);
                    left    = len_tab[j];
                    state   = ST_REDUNDANT;
                    return 1'b1;
                end
            end
            blk_idx = hdr_cnt;
            left    = '0;
            state   = ST_PRIMARY;
            return 1'b0;
        endfunction

        function bit take_header_byte(t_in_beat b, output t_out_beat r);
            bit pend;
            if (hdr_byte_idx == 0) begin
                if (b.data_byte[HDR_F_BIT] == HDR_PRIMARY) begin
                    pend = seek_next_block(0);
                    if (!b.last_byte)
                        return 1'b0;
                    state = ST_WAIT_FIRST;
                    // Packet ends on the primary header: empty primary, or early end if
                    // redundant bytes are still owed.
                    r = pack_beat(8'h00, b.pkt_timestamp, b.pkt_seq, b.pkt_mark,
                                  1'b1, 1'b0, !pend, pend);
                    return 1'b1;
                end
                if (hdr_cnt >= NBLK) begin
                    overflow = 1'b1;
                    state    = ST_DISCARD;
                end else begin
                    hdr_byte_idx = 2'd1;
                end
            end else if (hdr_byte_idx == 1) begin
                held         = b.data_byte;
                hdr_byte_idx = 2'd2;
            end else if (hdr_byte_idx == 2) begin
                if (hdr_cnt < NBLK)
                    off_tab[hdr_cnt] = {held, b.data_byte[7:2]};
                held         = {6'b0, b.data_byte[1:0]};
                hdr_byte_idx = 2'd3;
            end else begin
                if (hdr_cnt < NBLK) begin
                    len_tab[hdr_cnt] = {held[1:0], b.data_byte};
                    hdr_cnt++;
                end
                hdr_byte_idx = 2'd0;
            end
            if (b.last_byte) begin
                state = ST_WAIT_FIRST;
                r = pack_beat(8'h00, b.pkt_timestamp, b.pkt_seq, b.pkt_mark,
                              1'b1, 1'b0, 1'b0, 1'b1);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function bit recover_block_byte(t_in_beat b, output t_out_beat r);
            logic [3:0]  idx;
            logic [13:0] off;
            logic        fin, err;
            if (!codec_on)
                return 1'b0;
            if (state == ST_WAIT_FIRST) begin
                if (!b.is_redundant_format) begin
                    r = pack_beat(b.data_byte, b.pkt_timestamp, b.pkt_seq, b.pkt_mark,
                                  b.last_byte, 1'b0, 1'b0, 1'b0);
                    state = b.last_byte ? ST_WAIT_FIRST : ST_PLAIN;
                    return 1'b1;
                end
                hdr_cnt      = '0;
                hdr_byte_idx = '0;
                held         = '0;
                blk_idx      = '0;
                left         = '0;
                overflow     = 1'b0;
                state        = ST_HEADERS;
            end
            case (state)
                ST_PLAIN, ST_PRIMARY: begin
                    r = pack_beat(b.data_byte, b.pkt_timestamp, b.pkt_seq, b.pkt_mark,
                                  b.last_byte, 1'b0, 1'b0, 1'b0);
                    if (b.last_byte)
                        state = ST_WAIT_FIRST;
                    return 1'b1;
                end
                ST_HEADERS:
                    return take_header_byte(b, r);
                ST_REDUNDANT: begin
                    idx  = blk_idx;
                    off  = (idx < NBLK) ? off_tab[idx] : '0;
                    left = left - 10'd1;
                    fin  = (left == 0);
                    err  = 1'b0;
                    if (fin) begin
                        if (seek_next_block(int'(idx) + 1) && b.last_byte)
                            err = 1'b1;
                    end else if (b.last_byte) begin
                        err = 1'b1;
                    end
                    if (b.last_byte) begin
                        state = ST_WAIT_FIRST;
                        fin   = 1'b1;
                    end
                    r = pack_beat(b.data_byte, b.pkt_timestamp - 32'(off),
                                  b.pkt_seq - 16'(hdr_cnt - idx), b.pkt_mark,
                                  fin, 1'b1, 1'b0, err);
                    return 1'b1;
                end
                default: begin
                    if (b.last_byte) begin
                        state = ST_WAIT_FIRST;
                        r = pack_beat(8'h00, b.pkt_timestamp, b.pkt_seq, b.pkt_mark,
                                      1'b1, 1'b0, 1'b0, 1'b1);
                        return 1'b1;
                    end
                    return 1'b0;
                end
            endcase
            return 1'b0;
        endfunction

        function void note_payload_byte(t_in_beat b);
            t_out_beat r;
            if (recover_block_byte(b, r))
                pending_block_bytes.insert(pending_block_bytes.size(), r);
        endfunction

        function void check_block_byte(t_out_beat got);
            t_out_beat want;
            string     diffs;
            checked++;
            if (got.from_redundant) red_beats++;
            if (got.error)          err_beats++;
            if (got.empty_block)    empty_beats++;
            if (pending_block_bytes.size() == 0) begin
                failures++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("block byte %0d arrived with nothing pending: %p", checked, got);
                return;
            end
            want  = pending_block_bytes[0];
            pending_block_bytes.delete(0);
            diffs = "";
            if (got.out_byte       !== want.out_byte)       diffs = {diffs, " out_byte"};
            if (got.out_timestamp  !== want.out_timestamp)  diffs = {diffs, " out_timestamp"};
            if (got.out_seq        !== want.out_seq)        diffs = {diffs, " out_seq"};
            if (got.out_mark       !== want.out_mark)       diffs = {diffs, " out_mark"};
            if (got.block_end      !== want.block_end)      diffs = {diffs, " block_end"};
            if (got.from_redundant !== want.from_redundant) diffs = {diffs, " from_redundant"};
            if (got.empty_block    !== want.empty_block)    diffs = {diffs, " empty_block"};
            if (got.error          !== want.error)          diffs = {diffs, " error"};
            if (diffs != "") begin
                failures++;
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("block byte %0d differs in%s\n  expected %p\n  actual   %p",
                             checked, diffs, want, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block hookup
    // ------------------------------------------------------------------
    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_beat  in_beat = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_beat;
    logic      cfg_we = 1'b0;
    logic      cfg_wdata = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    red_text_payload_deframer_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    text_block_tracker sb;
    logic [7:0]        pkt_bytes[$];     // payload of the packet being built
    int                live_bytes, ignored_bytes, stall_cycles;
    int                calm_left;
    bit                hold_off_request;
    bit                hold_off_done;

    // ------------------------------------------------------------------
    // Monitor: every handshake is judged on the rising edge, where the
    // inputs set up at the falling edge are stable.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                sb.check_block_byte(out_beat);
            if (in_valid && !in_stall) begin
                if (sb.codec_on)
                    live_bytes++;
                else
                    ignored_bytes++;
                sb.note_payload_byte(in_beat);
            end
            if (in_valid && in_stall)
                stall_cycles++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall runs, mostly short; one long hold-off on request
    // so the output and input registers both fill and the input stalls.
    // ------------------------------------------------------------------
    initial begin : receiver
        int run;
        int roll;
        run = 0;
        forever begin
            @(negedge clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_off_done = 1'b1;
                run = 0;
            end else if (run == 0) begin
                roll = $urandom_range(0, 99);
                if (roll < 5) begin
                    out_stall <= 1'b0;
                    run = $urandom_range(30, 80);
                end else if (roll < 60) begin
                    out_stall <= 1'b0;
                    run = $urandom_range(1, 12);
                end else if (roll < 90) begin
                    out_stall <= 1'b1;
                    run = $urandom_range(1, 3);
                end else if (roll < 97) begin
                    out_stall <= 1'b1;
                    run = $urandom_range(4, 10);
                end else begin
                    out_stall <= 1'b1;
                    run = $urandom_range(15, 40);
                end
                run = run - 1;
            end else begin
                run = run - 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Gap before the next beat: mostly none, some short, few long, with calm stretches.
    function automatic int pick_gap();
        int roll;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    // Offer one beat and hold it until accepted. Entered and left at a falling edge;
    // valid stays high across back-to-back beats.
    task automatic send_beat(input t_in_beat b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Append one byte to the packet being built.
    function automatic void put_pkt_byte(logic [7:0] v);
        pkt_bytes.insert(pkt_bytes.size(), v);
    endfunction

    function automatic void add_red_header(logic [6:0] pt, logic [13:0] off, logic [9:0] len);
        put_pkt_byte({HDR_FOLLOWS, pt});
        put_pkt_byte(off[13:6]);
        put_pkt_byte({off[5:0], len[9:8]});
        put_pkt_byte(len[7:0]);
    endfunction

    function automatic void add_primary_header(logic [6:0] pt);
        put_pkt_byte({HDR_PRIMARY, pt});
    endfunction

    function automatic void add_random_bytes(int n);
        int j;
        for (j = 0; j < n; j++)
            put_pkt_byte(8'($urandom));
    endfunction

    // Send the built packet with its header values on every beat, last on the final byte.
    task automatic send_packet(input bit red, input logic [31:0] ts, input logic [15:0] sq,
                               input bit mk);
        t_in_beat b;
        int       j;
        for (j = 0; j < pkt_bytes.size(); j++) begin
            b.data_byte           = pkt_bytes[j];
            b.last_byte           = (j == pkt_bytes.size() - 1);
            b.is_redundant_format = red;
            b.pkt_timestamp       = ts;
            b.pkt_seq             = sq;
            b.pkt_mark            = mk;
            send_beat(b);
        end
        pkt_bytes.delete();
    endtask

    // Redundant packet with random content; cut drops its tail at a random point
    // and lets lengths span the full field.
    task automatic send_redundant(input int nh, input bit cut, input logic [31:0] ts,
                                  input logic [15:0] sq, input bit mk);
        int         j, roll, data_len, keep;
        logic [9:0] len;
        data_len = 0;
        for (j = 0; j < nh; j++) begin
            roll = $urandom_range(0, 99);
            if (cut && roll < 40)
                len = 10'($urandom_range(0, 1023));
            else if (roll < 6)
                len = 10'($urandom_range(8, 40));
            else
                len = 10'($urandom_range(0, 5));
            add_red_header(7'($urandom), 14'($urandom), len);
            if (j < NBLK)
                data_len += len;
        end
        add_primary_header(7'($urandom));
        if (cut) begin
            add_random_bytes($urandom_range(0, 40));
            keep = $urandom_range(1, pkt_bytes.size());
            while (pkt_bytes.size() > keep)
                void'(pkt_bytes.pop_back());
        end else begin
            add_random_bytes(data_len + $urandom_range(0, 6));
        end
        send_packet(1'b1, ts, sq, mk);
    endtask

    // Loose beats with every field random, framing included.
    task automatic send_noise();
        t_in_beat b;
        int       n;
        n = $urandom_range(1, 6);
        repeat (n) begin
            b.data_byte           = 8'($urandom);
            b.last_byte           = ($urandom_range(0, 3) == 0);
            b.is_redundant_format = 1'($urandom);
            b.pkt_timestamp       = $urandom;
            b.pkt_seq             = 16'($urandom);
            b.pkt_mark            = 1'($urandom);
            send_beat(b);
        end
    endtask

    task automatic random_packet();
        int          roll, hroll, nh;
        logic [31:0] ts;
        logic [15:0] sq;
        bit          mk;
        roll = $urandom_range(0, 99);
        ts   = $urandom;
        sq   = 16'($urandom);
        mk   = 1'($urandom);
        // small values make offset and block-count subtraction wrap
        if ($urandom_range(0, 7) == 0) ts = $urandom_range(0, 3);
        if ($urandom_range(0, 7) == 0) sq = 16'($urandom_range(0, 3));
        if (roll < 25) begin
            add_random_bytes($urandom_range(1, 8));
            send_packet(1'b0, ts, sq, mk);
        end else if (roll < 92) begin
            hroll = $urandom_range(0, 99);
            if (hroll < 6)
                nh = NBLK;
            else if (hroll < 10)
                nh = $urandom_range(NBLK + 1, NBLK + 3);
            else
                nh = $urandom_range(0, 4);
            send_redundant(nh, roll >= 80, ts, sq, mk);
        end else begin
            send_noise();
        end
    endtask

    // Run random packets until target live bytes; ask once for the long hold-off.
    task automatic random_until(input int target);
        while (live_bytes < target) begin
            if (!hold_off_done && !hold_off_request && live_bytes > HOLD_AT)
                hold_off_request = 1'b1;
            random_packet();
        end
    endtask

    // Drop valid, let every pending block byte come out, then give the pipe time
    // to swallow bytes that produce nothing.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_block_bytes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_codec(input bit on);
        cfg_we    <= 1'b1;
        cfg_wdata <= on;
        @(posedge clk);
        sb.codec_on = on;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------
    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d block bytes still pending", sb.pending_block_bytes.size());
        $display("red_text_payload_deframer_unit regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        sb = new();
        live_bytes       = 0;
        ignored_bytes    = 0;
        stall_cycles     = 0;
        calm_left        = 0;
        hold_off_request = 1'b0;
        hold_off_done    = 1'b0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Codec is off out of reset: these bytes must vanish.
        repeat (2) send_noise();
        settle();
        write_codec(1'b1);

        // Directed: plain packet with all-ones header values
        put_pkt_byte(8'hff);
        send_packet(1'b0, 32'hffff_ffff, 16'hffff, 1'b1);
        // plain packet, all-zero header values
        put_pkt_byte(8'h00);
        put_pkt_byte(8'h5a);
        send_packet(1'b0, 32'h0, 16'h0, 1'b0);
        // max offset wraps the timestamp; an empty redundant block still uses a seq slot
        add_red_header(7'h7f, 14'h3fff, 10'd2);
        add_red_header(7'h00, 14'h0000, 10'd0);
        add_primary_header(7'h7f);
        put_pkt_byte(8'hff);
        put_pkt_byte(8'h00);
        add_random_bytes(1);
        send_packet(1'b1, 32'h10, 16'h1, 1'b1);
        // primary header is the last byte: empty primary
        add_primary_header(7'h00);
        send_packet(1'b1, $urandom, 16'($urandom), 1'b0);
        // last byte closes the last redundant block: no empty-primary beat
        add_red_header(7'h24, 14'h0155, 10'd1);
        add_primary_header(7'h24);
        add_random_bytes(1);
        send_packet(1'b1, $urandom, 16'($urandom), 1'b1);
        // packet ends inside a header
        add_red_header(7'h5b, 14'h1234, 10'd3);
        void'(pkt_bytes.pop_back());
        send_packet(1'b1, $urandom, 16'($urandom), 1'b0);
        // packet ends with redundant bytes still owed
        add_red_header(7'h10, 14'h2aaa, 10'd3);
        add_primary_header(7'h10);
        add_random_bytes(1);
        send_packet(1'b1, $urandom, 16'($urandom), 1'b1);

        // Random: open with one header too many, then the mix.
        send_redundant(NBLK + 1, 1'b0, $urandom, 16'($urandom), 1'($urandom));
        random_until(SPLIT_TARGET);
        settle();

        // Codec off mid-run: everything in this stretch is dropped.
        write_codec(1'b0);
        repeat (8) random_packet();
        settle();
        write_codec(1'b1);
        random_until(ITEM_TARGET);
        settle();

        if (sb.pending_block_bytes.size() != 0) begin
            sb.failures += sb.pending_block_bytes.size();
            $display("%0d block bytes never arrived", sb.pending_block_bytes.size());
        end

        $display("covered %0d payload bytes (%0d dropped with codec off), %0d block bytes checked",
                 live_bytes, ignored_bytes, sb.checked);
        $display("  %0d redundant, %0d error, %0d empty-primary beats; input stalled %0d cycles",
                 sb.red_beats, sb.err_beats, sb.empty_beats, stall_cycles);
        if (sb.failures == 0) begin
            $display("red_text_payload_deframer_unit regression: pass");
        end else begin
            $display("%0d failures, %0d mismatches", sb.failures, sb.mismatches);
            $display("red_text_payload_deframer_unit regression: fail");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/rtpd_pkg.sv
rtl/core/rtpd_in_reg.sv
rtl/core/rtpd_parser.sv
rtl/core/rtpd_out_reg.sv
rtl/core/red_text_payload_deframer_unit.sv
tb/red_text_payload_deframer_unit_test.sv
